/* hdl/assert_macros.svh */
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPFA_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("spfa same-cycle check failed");

// next-cycle implication
`define SPFA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("spfa next-cycle check failed");

`endif

/* hdl/spfa_pkg.sv */
`default_nettype none
package spfa_pkg;

  localparam int PAGES    = 512;
  localparam int PAGE_W   = $clog2(PAGES);
  localparam int COUNT_W  = 8;
  localparam int CFG_W    = 10;
  localparam int STRIDE_W = 9;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INC   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SAT       = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLE_LO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLE_HI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM      = 3'd4;

  typedef struct packed {
    logic [STRIDE_W-1:0] stride;
    logic [CFG_W-1:0]    reserved_below;
    logic [CFG_W-1:0]    hole_start;
    logic [CFG_W-1:0]    hole_end;
    logic [CFG_W-1:0]    memory_pages;
  } cfg_t;

  typedef struct packed {
    logic [PAGE_W-1:0] cand;
    logic              ok;
    logic [PAGE_W-1:0] sum;
  } probe_t;

endpackage
`default_nettype wire

/* hdl/spfa_count_ram.sv */
`default_nettype none
module spfa_count_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [spfa_pkg::PAGE_W-1:0]  waddr,
  input  wire logic [spfa_pkg::COUNT_W-1:0] wdata,
  input  wire logic [spfa_pkg::PAGE_W-1:0]  raddr,
  output logic      [spfa_pkg::COUNT_W-1:0] rdata
);

  logic [spfa_pkg::COUNT_W-1:0] mem [spfa_pkg::PAGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/spfa_probe.sv */
`default_nettype none
module spfa_probe (
  input  wire spfa_pkg::cfg_t                cfg,
  input  wire logic [spfa_pkg::PAGE_W-1:0]   base,
  input  wire logic                          skip_zero,
  output spfa_pkg::probe_t                   res
);

  localparam logic [spfa_pkg::PAGE_W:0] PAGES_V = (spfa_pkg::PAGE_W+1)'(spfa_pkg::PAGES);

  logic [spfa_pkg::PAGE_W-1:0] cand;
  logic [spfa_pkg::CFG_W-1:0]  cand_x;
  logic [spfa_pkg::PAGE_W:0]   sum_raw;
  logic                        in_hole;

  always_comb begin
    cand    = (skip_zero && (base == '0)) ? spfa_pkg::PAGE_W'(1) : base;
    cand_x  = spfa_pkg::CFG_W'(cand);
    in_hole = (cand_x >= cfg.hole_start) && (cand_x < cfg.hole_end);
    res.cand = cand;
    res.ok   = (int'(cand) < spfa_pkg::PAGES) &&
               (cand_x >= cfg.reserved_below) &&
               (cand_x < cfg.memory_pages) && !in_hole;
    // stride always below the page count, so one conditional subtract wraps
    sum_raw = {1'b0, base} + (spfa_pkg::PAGE_W+1)'(cfg.stride);
    if (sum_raw >= PAGES_V) begin
      res.sum = spfa_pkg::PAGE_W'(sum_raw - PAGES_V);
    end else begin
      res.sum = spfa_pkg::PAGE_W'(sum_raw);
    end
  end

endmodule
`default_nettype wire

/* hdl/strided_page_frame_allocator.sv */
// Page frame allocator with an 8-bit reference count per page, held in a
// 512-entry count memory. After reset the memory is swept to zero, one entry
// a cycle; in_ready stays low meanwhile while configuration writes are taken
// as usual. Free and increment go through read, check and write, then respond.
// Allocate probes one page per cycle through a single shared probe/adder unit
// and the one read port of the count memory, up to 511 probes when all of them
// miss. One request is handled at a time; in_ready is low from accept until
// the result word has been taken.
`default_nettype none
`include "assert_macros.svh"
module strided_page_frame_allocator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [spfa_pkg::OP_W-1:0]      in_op,
  input  wire logic [8:0]                     in_page,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [spfa_pkg::STATUS_W-1:0]  out_status,
  output logic      [8:0]                     out_granted_page,
  output logic      [spfa_pkg::COUNT_W-1:0]   out_count_after,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [spfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [spfa_pkg::CFG_W-1:0]     cfg_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_NEXT  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  localparam int PW = spfa_pkg::PAGE_W;
  localparam int CW = spfa_pkg::COUNT_W;
  localparam logic [PW-1:0] LAST_PAGE = PW'(spfa_pkg::PAGES - 1);

  logic [2:0]                  state_r, state_nxt;
  spfa_pkg::cfg_t              cfg_r, cfg_nxt;
  logic [PW-1:0]               next_probe_r, next_probe_nxt;
  logic [PW-1:0]               pos_r, pos_nxt;
  logic [PW-1:0]               tries_r, tries_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [PW-1:0]               cand_r, cand_nxt;
  logic                        cand_ok_r, cand_ok_nxt;
  logic [spfa_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [PW-1:0]               page_r, page_nxt;
  logic [PW-1:0]               clr_cnt_r, clr_cnt_nxt;
  logic [spfa_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [PW-1:0]               granted_r, granted_nxt;
  logic [CW-1:0]               after_r, after_nxt;

  logic                        ram_we;
  logic [PW-1:0]               ram_waddr;
  logic [CW-1:0]               ram_wdata;
  logic [PW-1:0]               ram_raddr;
  logic [CW-1:0]               ram_rdata;

  logic [PW-1:0]               pu_base;
  logic                        pu_skip;
  spfa_pkg::probe_t            pu_res;

  spfa_probe u_probe (
    .cfg       (cfg_r),
    .base      (pu_base),
    .skip_zero (pu_skip),
    .res       (pu_res)
  );

  spfa_count_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = (state_r == S_RESP);
  assign cfg_ready        = 1'b1;
  assign out_status       = status_r;
  assign out_granted_page = 9'(granted_r);
  assign out_count_after  = after_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        spfa_pkg::CFG_STRIDE:   cfg_nxt.stride         = cfg_data[spfa_pkg::STRIDE_W-1:0];
        spfa_pkg::CFG_RESERVED: cfg_nxt.reserved_below = cfg_data;
        spfa_pkg::CFG_HOLE_LO:  cfg_nxt.hole_start     = cfg_data;
        spfa_pkg::CFG_HOLE_HI:  cfg_nxt.hole_end       = cfg_data;
        spfa_pkg::CFG_MEM:      cfg_nxt.memory_pages   = cfg_data;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    next_probe_nxt = next_probe_r;
    pos_nxt        = pos_r;
    tries_nxt      = tries_r;
    chk_vld_nxt    = chk_vld_r;
    cand_nxt       = cand_r;
    cand_ok_nxt    = cand_ok_r;
    op_nxt         = op_r;
    page_nxt       = page_r;
    clr_cnt_nxt    = clr_cnt_r;
    status_nxt     = status_r;
    granted_nxt    = granted_r;
    after_nxt      = after_r;
    ram_we         = 1'b0;
    ram_waddr      = cand_r;
    ram_wdata      = '0;
    pu_base        = pos_r;
    pu_skip        = 1'b1;
    ram_raddr      = pu_res.cand;

    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + PW'(1);
        if (clr_cnt_r == LAST_PAGE) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_op;
          page_nxt    = PW'(in_page);
          pos_nxt     = next_probe_r;
          tries_nxt   = '0;
          chk_vld_nxt = 1'b0;
          granted_nxt = '0;
          after_nxt   = '0;
          status_nxt  = spfa_pkg::ST_OK;
          unique case (in_op)
            spfa_pkg::OP_ALLOC: state_nxt = S_PROBE;
            spfa_pkg::OP_FREE:  state_nxt = S_READ;
            spfa_pkg::OP_INC:   state_nxt = S_READ;
            default:            state_nxt = S_RESP;
          endcase
        end
      end
      S_PROBE: begin
        priority if (chk_vld_r && cand_ok_r && (ram_rdata == '0)) begin
          ram_we      = 1'b1;
          ram_waddr   = cand_r;
          ram_wdata   = CW'(1);
          status_nxt  = spfa_pkg::ST_OK;
          granted_nxt = cand_r;
          after_nxt   = CW'(1);
          state_nxt   = S_NEXT;
        end else if (tries_r != LAST_PAGE) begin
          cand_nxt    = pu_res.cand;
          cand_ok_nxt = pu_res.ok;
          chk_vld_nxt = 1'b1;
          pos_nxt     = pu_res.sum;
          tries_nxt   = tries_r + PW'(1);
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            status_nxt  = spfa_pkg::ST_NO_FREE;
            granted_nxt = '0;
            after_nxt   = '0;
            state_nxt   = S_RESP;
          end
        end
      end
      S_NEXT: begin
        pu_base        = cand_r;
        pu_skip        = 1'b0;
        next_probe_nxt = (pu_res.sum == '0) ? PW'(1) : pu_res.sum;
        state_nxt      = S_RESP;
      end
      S_READ: begin
        ram_raddr = page_r;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        pu_base   = page_r;
        pu_skip   = 1'b0;
        ram_waddr = page_r;
        state_nxt = S_RESP;
        if (op_r == spfa_pkg::OP_FREE) begin
          priority if (!pu_res.ok) begin
            status_nxt = spfa_pkg::ST_NOT_ALLOC;
            after_nxt  = ram_rdata;
          end else if (ram_rdata == '0) begin
            status_nxt = spfa_pkg::ST_ZERO;
            after_nxt  = '0;
          end else begin
            ram_we     = 1'b1;
            ram_wdata  = ram_rdata - CW'(1);
            after_nxt  = ram_rdata - CW'(1);
          end
        end else begin
          priority if (int'(page_r) >= spfa_pkg::PAGES) begin
            status_nxt = spfa_pkg::ST_NOT_ALLOC;
            after_nxt  = '0;
          end else if (ram_rdata == spfa_pkg::COUNT_MAX) begin
            status_nxt = spfa_pkg::ST_SAT;
            after_nxt  = ram_rdata;
          end else begin
            ram_we     = 1'b1;
            ram_wdata  = ram_rdata + CW'(1);
            after_nxt  = ram_rdata + CW'(1);
          end
        end
      end
      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      next_probe_r   <= PW'(1);
      chk_vld_r      <= 1'b0;
      cfg_r.stride         <= spfa_pkg::STRIDE_W'(3);
      cfg_r.reserved_below <= spfa_pkg::CFG_W'(128);
      cfg_r.hole_start     <= spfa_pkg::CFG_W'(160);
      cfg_r.hole_end       <= spfa_pkg::CFG_W'(256);
      cfg_r.memory_pages   <= spfa_pkg::CFG_W'(512);
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      next_probe_r <= next_probe_nxt;
      chk_vld_r    <= chk_vld_nxt;
      cfg_r        <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    tries_r   <= tries_nxt;
    cand_r    <= cand_nxt;
    cand_ok_r <= cand_ok_nxt;
    op_r      <= op_nxt;
    page_r    <= page_nxt;
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
    after_r   <= after_nxt;
  end

  `SPFA_ASSERT_SAME(a_no_overlap, 1'b1, !(in_ready && out_valid))
  `SPFA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `SPFA_ASSERT_SAME(a_probe_nonzero, 1'b1, next_probe_r != '0)
  `SPFA_ASSERT_SAME(a_grant_count_one,
    out_valid && (out_granted_page != '0), out_count_after == CW'(1))

endmodule
`default_nettype wire

/* tb/strided_page_frame_allocator_tb.sv */
module strided_page_frame_allocator_tb;

  localparam logic [spfa_pkg::OP_W-1:0] OP_NONE = 2'd3;
  localparam logic [spfa_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [spfa_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic TYPED = 1'b1;
  localparam logic PRED = 1'b0;
  localparam int LIMIT = 2500000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 600;
  localparam int SAT_RUN = 260;
  localparam int OWNED_MAX = 64;

  typedef struct packed {
    logic [spfa_pkg::STATUS_W-1:0] status;
    logic [8:0]                    granted;
    logic [spfa_pkg::COUNT_W-1:0]  count;
  } resp_t;

  typedef struct packed {
    logic [spfa_pkg::OP_W-1:0] op;
    logic [8:0]                page;
    logic                      fixed;
    resp_t                     want;
  } dir_row_t;

  typedef struct packed {
    logic [9:0] stride;
    logic [9:0] resv;
    logic [9:0] hole_lo;
    logic [9:0] hole_hi;
    logic [9:0] mem;
    bit         shuffle;
    bit         calm;
    int         items;
  } reg_set_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [spfa_pkg::OP_W-1:0] in_op;
  logic [8:0] in_page;
  logic out_valid;
  logic out_ready;
  logic [spfa_pkg::STATUS_W-1:0] out_status;
  logic [8:0] out_granted_page;
  logic [spfa_pkg::COUNT_W-1:0] out_count_after;
  logic cfg_valid;
  logic cfg_ready;
  logic [spfa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [spfa_pkg::CFG_W-1:0] cfg_data;

  logic hint_fixed;
  resp_t hint_want;

  // predictor state
  logic [spfa_pkg::COUNT_W-1:0] page_refs [0:spfa_pkg::PAGES-1];
  logic [8:0] probe_at;
  logic [8:0] stride_reg;
  logic [9:0] resv_reg;
  logic [9:0] hole_lo_reg;
  logic [9:0] hole_hi_reg;
  logic [9:0] mem_reg;

  resp_t pending [$];
  logic [8:0] owned_pages [$];
  int sent = 0;
  int words_out = 0;
  int cfg_writes = 0;
  int errors = 0;
  int status_hits [0:7];
  bit calm = 1'b0;

  dir_row_t dir_rows [0:22] = '{
    '{spfa_pkg::OP_FREE,  9'd0,   TYPED, '{spfa_pkg::ST_NOT_ALLOC, 9'd0, 8'd0}},
    '{spfa_pkg::OP_FREE,  9'd300, TYPED, '{spfa_pkg::ST_ZERO,      9'd0, 8'd0}},
    '{spfa_pkg::OP_INC,   9'd0,   TYPED, '{spfa_pkg::ST_OK,        9'd0, 8'd1}},
    '{spfa_pkg::OP_FREE,  9'd0,   TYPED, '{spfa_pkg::ST_NOT_ALLOC, 9'd0, 8'd1}},
    '{OP_NONE,            9'd511, TYPED, '{spfa_pkg::ST_OK,        9'd0, 8'd0}},
    '{spfa_pkg::OP_ALLOC, 9'd0,   PRED,  '0},
    '{spfa_pkg::OP_ALLOC, 9'd511, PRED,  '0},
    '{spfa_pkg::OP_INC,   9'd511, TYPED, '{spfa_pkg::ST_OK,        9'd0, 8'd1}},
    '{spfa_pkg::OP_INC,   9'd511, TYPED, '{spfa_pkg::ST_OK,        9'd0, 8'd2}},
    '{spfa_pkg::OP_FREE,  9'd511, TYPED, '{spfa_pkg::ST_OK,        9'd0, 8'd1}},
    '{spfa_pkg::OP_FREE,  9'd511, TYPED, '{spfa_pkg::ST_OK,        9'd0, 8'd0}},
    '{spfa_pkg::OP_FREE,  9'd511, TYPED, '{spfa_pkg::ST_ZERO,      9'd0, 8'd0}},
    '{spfa_pkg::OP_FREE,  9'd127, TYPED, '{spfa_pkg::ST_NOT_ALLOC, 9'd0, 8'd0}},
    '{spfa_pkg::OP_FREE,  9'd128, TYPED, '{spfa_pkg::ST_ZERO,      9'd0, 8'd0}},
    '{spfa_pkg::OP_FREE,  9'd159, TYPED, '{spfa_pkg::ST_ZERO,      9'd0, 8'd0}},
    '{spfa_pkg::OP_FREE,  9'd160, TYPED, '{spfa_pkg::ST_NOT_ALLOC, 9'd0, 8'd0}},
    '{spfa_pkg::OP_FREE,  9'd255, TYPED, '{spfa_pkg::ST_NOT_ALLOC, 9'd0, 8'd0}},
    '{spfa_pkg::OP_FREE,  9'd256, TYPED, '{spfa_pkg::ST_ZERO,      9'd0, 8'd0}},
    '{spfa_pkg::OP_INC,   9'd256, TYPED, '{spfa_pkg::ST_OK,        9'd0, 8'd1}},
    '{spfa_pkg::OP_ALLOC, 9'd170, PRED,  '0},
    '{spfa_pkg::OP_FREE,  9'd130, PRED,  '0},
    '{spfa_pkg::OP_ALLOC, 9'd341, PRED,  '0},
    '{OP_NONE,            9'd0,   TYPED, '{spfa_pkg::ST_OK,        9'd0, 8'd0}}
  };

  reg_set_t phases [0:7] = '{
    '{10'd3,    10'd128, 10'd160,  10'd256, 10'd512,  1'b0, 1'b0, 60},
    '{10'd1,    10'd1,   10'd0,    10'd0,   10'd512,  1'b0, 1'b0, 70},
    '{10'd511,  10'd512, 10'd512,  10'd512, 10'd1,    1'b0, 1'b1, 40},
    '{10'd0,    10'd1,   10'd0,    10'd0,   10'd512,  1'b0, 1'b0, 50},
    '{10'd5,    10'd400, 10'd450,  10'd420, 10'd480,  1'b0, 1'b0, 80},
    '{10'd1023, 10'd0,   10'd1023, 10'd0,   10'd1023, 1'b0, 1'b1, 60},
    '{10'd0,    10'd0,   10'd0,    10'd0,   10'd0,    1'b1, 1'b0, 70},
    '{10'd2,    10'd500, 10'd505,  10'd508, 10'd512,  1'b0, 1'b0, 60}
  };

  strided_page_frame_allocator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_page          (in_page),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_granted_page (out_granted_page),
    .out_count_after  (out_count_after),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_model();
    foreach (page_refs[i]) page_refs[i] = '0;
    probe_at = 9'd1;
    stride_reg = 9'd3;
    resv_reg = 10'd128;
    hole_lo_reg = 10'd160;
    hole_hi_reg = 10'd256;
    mem_reg = 10'd512;
  endfunction

  function automatic bit usable(input int p);
    return p >= resv_reg && p < mem_reg && !(p >= hole_lo_reg && p < hole_hi_reg);
  endfunction

  function automatic resp_t serve_request(input logic [spfa_pkg::OP_W-1:0] op,
                                          input logic [8:0] pg);
    resp_t r;
    int pos;
    int cand;
    int nxt;
    r = '0;
    case (op)
      spfa_pkg::OP_ALLOC: begin
        r.status = spfa_pkg::ST_NO_FREE;
        pos = int'(probe_at);
        for (int t = 0; t < spfa_pkg::PAGES - 1; t++) begin
          cand = (pos == 0) ? 1 : pos;
          if (usable(cand) && page_refs[cand] == 0) begin
            page_refs[cand] = 8'd1;
            nxt = (cand + int'(stride_reg)) % spfa_pkg::PAGES;
            probe_at = (nxt == 0) ? 9'd1 : 9'(nxt);
            r.status = spfa_pkg::ST_OK;
            r.granted = 9'(cand);
            r.count = 8'd1;
            owned_pages.push_back(9'(cand));
            if (owned_pages.size() > OWNED_MAX) void'(owned_pages.pop_front());
            break;
          end
          pos = (pos + int'(stride_reg)) % spfa_pkg::PAGES;
        end
      end
      spfa_pkg::OP_FREE: begin
        if (!usable(int'(pg))) begin
          r.status = spfa_pkg::ST_NOT_ALLOC;
          r.count = page_refs[pg];
        end else if (page_refs[pg] == 0) begin
          r.status = spfa_pkg::ST_ZERO;
        end else begin
          page_refs[pg] = page_refs[pg] - 8'd1;
          r.count = page_refs[pg];
        end
      end
      spfa_pkg::OP_INC: begin
        if (page_refs[pg] == spfa_pkg::COUNT_MAX) begin
          r.status = spfa_pkg::ST_SAT;
          r.count = spfa_pkg::COUNT_MAX;
        end else begin
          page_refs[pg] = page_refs[pg] + 8'd1;
          r.count = page_refs[pg];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [spfa_pkg::OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return spfa_pkg::OP_ALLOC;
    if (r < 65) return spfa_pkg::OP_FREE;
    if (r < 95) return spfa_pkg::OP_INC;
    return OP_NONE;
  endfunction

  function automatic logic [8:0] pick_page();
    if (owned_pages.size() > 0 && $urandom_range(0, 1) == 1)
      return owned_pages[$urandom_range(0, owned_pages.size() - 1)];
    return 9'($urandom_range(0, spfa_pkg::PAGES - 1));
  endfunction

  task automatic submit(input logic [spfa_pkg::OP_W-1:0] op, input logic [8:0] pg,
                        input logic fixed, input resp_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_page <= pg;
    hint_fixed <= fixed;
    hint_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [spfa_pkg::CFG_IDX_W-1:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input reg_set_t s);
    write_reg(spfa_pkg::CFG_STRIDE, s.stride);
    write_reg(spfa_pkg::CFG_RESERVED, s.resv);
    write_reg(spfa_pkg::CFG_HOLE_LO, s.hole_lo);
    write_reg(spfa_pkg::CFG_HOLE_HI, s.hole_hi);
    write_reg(spfa_pkg::CFG_MEM, s.mem);
    // unmapped index must leave everything alone
    write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 10'($urandom_range(0, 1023)));
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : scoreboard
    resp_t want;
    resp_t seen;
    resp_t calc;
    if (!rst_n) begin
      clear_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          spfa_pkg::CFG_STRIDE:   stride_reg = cfg_data[8:0];
          spfa_pkg::CFG_RESERVED: resv_reg = cfg_data;
          spfa_pkg::CFG_HOLE_LO:  hole_lo_reg = cfg_data;
          spfa_pkg::CFG_HOLE_HI:  hole_hi_reg = cfg_data;
          spfa_pkg::CFG_MEM:      mem_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        words_out++;
        seen = '{out_status, out_granted_page, out_count_after};
        if (pending.size() == 0) begin
          $display("%0t: result word with nothing pending (status %0d page %0d count %0d)",
                   $time, seen.status, seen.granted, seen.count);
          errors++;
        end else begin
          want = pending.pop_front();
          status_hits[want.status]++;
          if (seen.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, seen.status);
            errors++;
          end
          if (seen.granted !== want.granted) begin
            $display("%0t: granted_page expected %0d got %0d", $time, want.granted,
                     seen.granted);
            errors++;
          end
          if (seen.count !== want.count) begin
            $display("%0t: count_after expected %0d got %0d", $time, want.count, seen.count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        calc = serve_request(in_op, in_page);
        pending.push_back(hint_fixed ? hint_want : calc);
      end
    end
  end

  initial begin : sink
    int stall;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      // long back-pressure so the allocator stalls its input
      if (!held && words_out >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    reg_set_t s;
    logic [8:0] sat_page;
    foreach (status_hits[i]) status_hits[i] = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= '0;
    in_page <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    hint_fixed <= 1'b0;
    hint_want <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      submit(dir_rows[i].op, dir_rows[i].page, dir_rows[i].fixed, dir_rows[i].want);

    foreach (phases[p]) begin
      s = phases[p];
      if (s.shuffle) begin
        s.stride = 10'($urandom_range(0, 1023));
        s.resv = 10'($urandom_range(0, 1023));
        s.hole_lo = 10'($urandom_range(0, 1023));
        s.hole_hi = 10'($urandom_range(0, 1023));
        s.mem = 10'($urandom_range(0, 1023));
      end
      in_valid <= 1'b0;
      while (words_out < sent) @(posedge clk);
      calm = s.calm;
      program_regs(s);
      repeat (s.items) submit(pick_op(), pick_page(), PRED, '0);
      if (p == 0) begin
        // drive one page into saturation and back
        sat_page = 9'($urandom_range(0, spfa_pkg::PAGES - 1));
        repeat (SAT_RUN) submit(spfa_pkg::OP_INC, sat_page, PRED, '0);
        submit(spfa_pkg::OP_FREE, sat_page, PRED, '0);
        submit(spfa_pkg::OP_INC, sat_page, PRED, '0);
      end
    end

    in_valid <= 1'b0;
    while (words_out < sent) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending.size());
      errors++;
    end
    $display("%0d requests, %0d register writes, %0d register settings incl. extremes",
             sent, cfg_writes, $size(phases) + 1);
    $display("results: ok %0d, no free %0d, not allocatable %0d, zero %0d, saturated %0d",
             status_hits[spfa_pkg::ST_OK], status_hits[spfa_pkg::ST_NO_FREE],
             status_hits[spfa_pkg::ST_NOT_ALLOC], status_hits[spfa_pkg::ST_ZERO],
             status_hits[spfa_pkg::ST_SAT]);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
